@@ src/es2c_pkg.sv @@
// ----------------------------------------------------------------------------
// es2c_pkg: shared types and constants for the epoch-to-calendar converter
// Holds calendar constants, the sequencer state type, the subtractor request
// and response structs, and the month-length lookup.
// ----------------------------------------------------------------------------
package es2c_pkg;

  // Field widths of the item channels
  localparam int EPOCH_W  = 32;
  localparam int YEAR_W   = 7;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Calendar constants
  localparam logic [31:0] EPOCH_2000   = 32'd946684800;
  localparam logic [31:0] EPOCH_2100   = 32'd4102444800;
  // Seconds from 2000-01-01 00:00:00 to 2099-12-31 23:59:59
  localparam logic [31:0] SPAN_LAST    = 32'd3155759999;
  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
  localparam logic [31:0] SEC_PER_MIN  = 32'd60;
  localparam logic [31:0] DAYS_LEAP    = 32'd366;
  localparam logic [31:0] DAYS_COMMON  = 32'd365;

  // Widths for the restoring divisions: day quotient, second of day, quotient, step
  localparam int DAYS_Q_W = 16;   // day count below 36525
  localparam int SOD_W    = 17;   // second of day below 86400
  localparam int QUO_W    = 16;
  localparam int STEP_W   = 4;

  localparam logic [YEAR_W-1:0]  YEAR_LAST  = 7'd99;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;  // December, zero based
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_YEARS,
    ST_MONTHS,
    ST_HOURS,
    ST_MINUTES,
    ST_DONE
  } es2c_state_t;

  typedef struct packed {
    logic [31:0] minuend;
    logic [31:0] subtrahend;
  } es2c_sub_req_t;

  typedef struct packed {
    logic        ge;     // minuend >= subtrahend
    logic [31:0] diff;
  } es2c_sub_rsp_t;

  // Days in a zero-based month; February follows the leap flag
  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m,
                                           input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ src/es2c_if.sv @@
// ----------------------------------------------------------------------------
// es2c_if: item channels of the epoch-to-calendar converter
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface es2c_in_if;
  import es2c_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2c_out_if;
  import es2c_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year_offset;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day_of_month;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;
  logic                out_of_range;

  modport source (output valid, output year_offset, output month, output day_of_month,
                  output hour, output minute, output second, output out_of_range,
                  input ready);
  modport sink   (input valid, input year_offset, input month, input day_of_month,
                  input hour, input minute, input second, input out_of_range,
                  output ready);
endinterface

@@ src/epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: Unix seconds to calendar date, years 2000..2099
// Iterative converter built around one shared compare-and-subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one 32-bit Unix time per item; out_chan returns one item
//   with year offset from 2000, month, day of month, hour, minute, second
//   and an out_of_range flag. Times before 2000 saturate to 2000-01-01
//   00:00:00, times from 2100 on to 2099-12-31 23:59:59, both with the flag.
//   Each item passes one subtractor step per cycle: 16 steps of day division,
//   up to 100 year steps, up to 12 month steps, 5 hour and 6 minute steps.
//   The time from accept to result valid depends on the year and month
//   loops. The input takes one item at a time and is ready only while the
//   sequencer is idle, so it takes no new item before the last is finished.
//   The result sits in an output register. While the receiver stalls, the
//   next item is accepted and converted, and waits in its last state until
//   the output register frees up.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic         clk,
  input  logic         rst_n,
  es2c_in_if.sink      in_chan,
  es2c_out_if.source   out_chan
);
  import es2c_pkg::*;

  es2c_state_t state_r, state_nxt;

  logic [31:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SOD_W-1:0]    sod_r, sod_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  mon_r, mon_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [MINUTE_W-1:0] min_r, min_nxt;
  logic                oor_r, oor_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]   o_year_r;
  logic [MONTH_W-1:0]  o_month_r;
  logic [DAY_W-1:0]    o_day_r;
  logic [HOUR_W-1:0]   o_hour_r;
  logic [MINUTE_W-1:0] o_min_r;
  logic [SECOND_W-1:0] o_sec_r;
  logic                o_oor_r;

  es2c_sub_req_t sub_req;
  es2c_sub_rsp_t sub_rsp;

  logic              in_fire;
  logic              out_load;
  logic              leap;
  logic              last_step;
  logic              year_take;
  logic              month_take;
  logic [31:0]       rem_step;
  logic [QUO_W-1:0]  quo_step;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign leap      = (year_r[1:0] == 2'b00);
  assign last_step = (step_r == '0);

  // Shared subtractor
  es2c_sub_unit u_sub (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  // Pick the subtrahend for the current step
  always_comb begin
    sub_req.minuend = rem_r;
    case (state_r)
      ST_DAYS:    sub_req.subtrahend = SEC_PER_DAY << step_r;
      ST_YEARS:   sub_req.subtrahend = leap ? DAYS_LEAP : DAYS_COMMON;
      ST_MONTHS:  sub_req.subtrahend = 32'(month_len(mon_r, leap));
      ST_HOURS:   sub_req.subtrahend = SEC_PER_HOUR << step_r;
      ST_MINUTES: sub_req.subtrahend = SEC_PER_MIN << step_r;
      default:    sub_req.subtrahend = '0;
    endcase
  end

  // Restoring division step and loop exit conditions
  assign rem_step   = sub_rsp.ge ? sub_rsp.diff : rem_r;
  assign quo_step   = {quo_r[QUO_W-2:0], sub_rsp.ge};
  assign year_take  = sub_rsp.ge && (year_r != YEAR_LAST);
  assign month_take = sub_rsp.ge && (mon_r != MONTH_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_DAYS;
      ST_DAYS:    if (last_step) state_nxt = ST_YEARS;
      ST_YEARS:   if (!year_take) state_nxt = ST_MONTHS;
      ST_MONTHS:  if (!month_take) state_nxt = ST_HOURS;
      ST_HOURS:   if (last_step) state_nxt = ST_MINUTES;
      ST_MINUTES: if (last_step) state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    sod_nxt  = sod_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    oor_nxt  = oor_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // Saturate outside 2000..2099, else offset to 2000
          if (in_chan.epoch_seconds < EPOCH_2000) begin
            rem_nxt = '0;
            oor_nxt = 1'b1;
          end else if (in_chan.epoch_seconds >= EPOCH_2100) begin
            rem_nxt = SPAN_LAST;
            oor_nxt = 1'b1;
          end else begin
            rem_nxt = in_chan.epoch_seconds - EPOCH_2000;
            oor_nxt = 1'b0;
          end
          quo_nxt  = '0;
          step_nxt = STEP_W'(DAYS_Q_W - 1);
          year_nxt = '0;
          mon_nxt  = '0;
        end
      end
      ST_DAYS: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          // Second of day stays aside; day count becomes the remainder
          sod_nxt = rem_step[SOD_W-1:0];
          rem_nxt = 32'(quo_step);
        end
      end
      ST_YEARS: begin
        if (year_take) begin
          rem_nxt  = sub_rsp.diff;
          year_nxt = year_r + 1'b1;
        end
      end
      ST_MONTHS: begin
        if (month_take) begin
          rem_nxt = sub_rsp.diff;
          mon_nxt = mon_r + 1'b1;
        end else begin
          day_nxt  = rem_r[DAY_W-1:0] + 1'b1;
          rem_nxt  = 32'(sod_r);
          quo_nxt  = '0;
          step_nxt = STEP_W'(HOUR_W - 1);
        end
      end
      ST_HOURS: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          hour_nxt = quo_step[HOUR_W-1:0];
          quo_nxt  = '0;
          step_nxt = STEP_W'(MINUTE_W - 1);
        end
      end
      ST_MINUTES: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          min_nxt = quo_step[MINUTE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold while stalled, reload from the finished item
  assign out_valid_nxt = (out_valid_r && !out_chan.ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    sod_r  <= sod_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    oor_r  <= oor_nxt;
  end

  // Capture the finished item; the second is what the minute division left
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_year_r  <= year_r;
      o_month_r <= mon_r + 1'b1;
      o_day_r   <= day_r;
      o_hour_r  <= hour_r;
      o_min_r   <= min_r;
      o_sec_r   <= rem_r[SECOND_W-1:0];
      o_oor_r   <= oor_r;
    end
  end

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.year_offset   = o_year_r;
  assign out_chan.month         = o_month_r;
  assign out_chan.day_of_month  = o_day_r;
  assign out_chan.hour          = o_hour_r;
  assign out_chan.minute        = o_min_r;
  assign out_chan.second        = o_sec_r;
  assign out_chan.out_of_range  = o_oor_r;

endmodule

@@ src/es2c_sub_unit.sv @@
// ----------------------------------------------------------------------------
// es2c_sub_unit: shared compare-and-subtract unit
// One 32-bit subtractor; the borrow gives the compare, the difference the
// new remainder. Every step of the converter goes through it.
// ----------------------------------------------------------------------------
module es2c_sub_unit (
  input  es2c_pkg::es2c_sub_req_t req,
  output es2c_pkg::es2c_sub_rsp_t rsp
);
  import es2c_pkg::*;

  logic [32:0] wide;

  // Subtract with one extra bit to catch the borrow
  assign wide     = {1'b0, req.minuend} - {1'b0, req.subtrahend};
  assign rsp.ge   = ~wide[32];
  assign rsp.diff = wide[31:0];

endmodule
